>>> sv/tmpr_pkg.sv
// types, codes and tables shared by the tile map pixel renderer
package tmpr_pkg;

  localparam int IDX_W = 14;

  typedef enum logic [1:0] {
    CMD_MAP_WR  = 2'd0,
    CMD_CHAR_WR = 2'd1,
    CMD_PAL_WR  = 2'd2,
    CMD_RENDER  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_START_X     = 3'd0,
    REG_START_Y     = 3'd1,
    REG_MAP_WIDTH   = 3'd2,
    REG_MAP_ENTRIES = 3'd3,
    REG_CHAR_BYTES  = 3'd4,
    REG_PAL_ENTRIES = 3'd5,
    REG_ALPHA       = 3'd6
  } reg_idx_t;

  typedef struct packed {
    cmd_t        command;
    logic [14:0] address;
    logic [15:0] data;
    logic [8:0]  pixel_x;
    logic [8:0]  pixel_y;
  } in_item_t;

  typedef struct packed {
    logic [31:0] rgba;
    logic        drawn;
  } out_item_t;

  // round(v * 255 / 31) for a 5-bit channel
  localparam logic [7:0] EXPAND5 [32] = '{
    8'd0,   8'd8,   8'd16,  8'd25,  8'd33,  8'd41,  8'd49,  8'd58,
    8'd66,  8'd74,  8'd82,  8'd90,  8'd99,  8'd107, 8'd115, 8'd123,
    8'd132, 8'd140, 8'd148, 8'd156, 8'd165, 8'd173, 8'd181, 8'd189,
    8'd197, 8'd206, 8'd214, 8'd222, 8'd230, 8'd239, 8'd247, 8'd255
  };

endpackage

>>> sv/tmpr_ram.sv
// generic single-clock ram with one write port and one registered read port
module tmpr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/tile_map_pixel_render.sv
// tile map pixel renderer top level: write commands and pipelined pixel lookup
// One transaction per clock is taken in while the pipeline does not stall; a render
// result reaches the output register through a chain of lookups: the tile row multiply
// is registered at the accepting edge, then come the map, character and palette memory
// reads, each registered, then the color expansion into the output register. Store
// writes ride the same pipeline and land in the stage that reads that store, so
// reads and writes stay in transaction order. The pipeline stalls only while a render
// result sits at the last stage and the output register is full and not taken.
module tile_map_pixel_render #(
  parameter int MAP_DEPTH     = 2048,
  parameter int CHAR_DEPTH    = 32768,
  parameter int PALETTE_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tmpr_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output tmpr_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_wdata
);

  localparam int MAW = $clog2(MAP_DEPTH);
  localparam int CAW = $clog2(CHAR_DEPTH);
  localparam int PAW = $clog2(PALETTE_DEPTH);
  localparam int IW  = tmpr_pkg::IDX_W;

  // configuration
  logic [5:0]  start_x_r, start_y_r;
  logic [6:0]  map_width_r;
  logic [11:0] map_entries_r;
  logic [15:0] char_bytes_r;
  logic [4:0]  pal_entries_r;
  logic [7:0]  alpha_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r     <= '0;
      start_y_r     <= '0;
      map_width_r   <= 7'd32;
      map_entries_r <= '0;
      char_bytes_r  <= '0;
      pal_entries_r <= '0;
      alpha_r       <= 8'd255;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tmpr_pkg::REG_START_X:     start_x_r     <= cfg_wdata[5:0];
        tmpr_pkg::REG_START_Y:     start_y_r     <= cfg_wdata[5:0];
        tmpr_pkg::REG_MAP_WIDTH:   map_width_r   <= cfg_wdata[6:0];
        tmpr_pkg::REG_MAP_ENTRIES: map_entries_r <= cfg_wdata[11:0];
        tmpr_pkg::REG_CHAR_BYTES:  char_bytes_r  <= cfg_wdata;
        tmpr_pkg::REG_PAL_ENTRIES: pal_entries_r <= cfg_wdata[4:0];
        tmpr_pkg::REG_ALPHA:       alpha_r       <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // pipeline registers
  logic                 v1_r, v2_r, v3_r, v4_r;
  tmpr_pkg::cmd_t       cmd1_r, cmd2_r, cmd3_r, cmd4_r;
  logic [14:0]          addr1_r, addr2_r, addr3_r;
  logic [15:0]          data1_r;
  logic [14:0]          data2_r, data3_r;
  logic [2:0]           fx1_r, fy1_r, fx2_r, fy2_r;
  logic [IW-1:0]        prod1_r;
  logic [10:0]          col1_r;
  logic                 ok2_r, ok3_r, ok4_r;
  logic                 odd3_r;
  logic                 out_valid_r;
  tmpr_pkg::out_item_t  out_item_r;

  logic adv, in_acc;

  assign adv    = !(v4_r && (cmd4_r == tmpr_pkg::CMD_RENDER) && out_valid_r && !out_ready);
  assign in_acc = in_valid && adv;
  assign in_ready = adv;

  // tile position and map index parts
  logic [6:0]    icx, icy, stride;
  logic [10:0]   col_nxt;
  logic [IW-1:0] prod_nxt;

  always_comb begin
    icx = {1'b0, in_item.pixel_x[8:3]} + {1'b0, start_x_r};
    icy = {1'b0, in_item.pixel_y[8:3]} + {1'b0, start_y_r};
    stride = (map_width_r > 7'd32) ? {1'b0, map_width_r[6:1]} : map_width_r;
    col_nxt = (icx[6:5] == 2'b01) ? {6'b100000, icx[4:0]} : {4'b0000, icx};
    prod_nxt = IW'(icy) * IW'(stride);
  end

  // map lookup
  logic [IW-1:0]   idx;
  logic            map_ok;
  logic            map_we;
  logic [15:0]     map_rdata;

  assign idx    = prod1_r + IW'(col1_r);
  assign map_ok = (idx < IW'(map_entries_r)) && (idx < IW'(MAP_DEPTH));
  assign map_we = adv && v1_r && (cmd1_r == tmpr_pkg::CMD_MAP_WR) &&
                  ({1'b0, addr1_r} < 16'(MAP_DEPTH));

  tmpr_ram #(.WIDTH(16), .DEPTH(MAP_DEPTH)) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (addr1_r[MAW-1:0]),
    .wdata (data1_r),
    .re    (adv),
    .raddr (idx[MAW-1:0]),
    .rdata (map_rdata)
  );

  // character lookup
  logic [2:0]  ix, iy;
  logic [14:0] byte_addr;
  logic        char_ok;
  logic        char_we;
  logic [7:0]  char_rdata;

  always_comb begin
    ix = map_rdata[10] ? ~fx2_r : fx2_r;
    iy = map_rdata[11] ? ~fy2_r : fy2_r;
    byte_addr = {map_rdata[9:0], iy, ix[2:1]};
    char_ok = ok2_r && ({1'b0, byte_addr} < char_bytes_r) &&
              ({1'b0, byte_addr} < 16'(CHAR_DEPTH));
  end

  assign char_we = adv && v2_r && (cmd2_r == tmpr_pkg::CMD_CHAR_WR) &&
                   ({1'b0, addr2_r} < 16'(CHAR_DEPTH));

  tmpr_ram #(.WIDTH(8), .DEPTH(CHAR_DEPTH)) u_char_ram (
    .clk   (clk),
    .we    (char_we),
    .waddr (addr2_r[CAW-1:0]),
    .wdata (data2_r[7:0]),
    .re    (adv),
    .raddr (byte_addr[CAW-1:0]),
    .rdata (char_rdata)
  );

  // palette lookup
  logic [3:0]  nib;
  logic        pal_ok;
  logic        pal_we;
  logic [14:0] pal_rdata;

  assign nib    = odd3_r ? char_rdata[7:4] : char_rdata[3:0];
  assign pal_ok = ok3_r && (nib != 4'd0) && ({1'b0, nib} < pal_entries_r) &&
                  ({1'b0, nib} < 5'(PALETTE_DEPTH));
  assign pal_we = adv && v3_r && (cmd3_r == tmpr_pkg::CMD_PAL_WR) &&
                  ({1'b0, addr3_r} < 16'(PALETTE_DEPTH));

  tmpr_ram #(.WIDTH(15), .DEPTH(PALETTE_DEPTH)) u_pal_ram (
    .clk   (clk),
    .we    (pal_we),
    .waddr (addr3_r[PAW-1:0]),
    .wdata (data3_r),
    .re    (adv),
    .raddr (nib[PAW-1:0]),
    .rdata (pal_rdata)
  );

  // color expansion
  tmpr_pkg::out_item_t out_item_nxt;

  always_comb begin
    out_item_nxt.drawn = ok4_r;
    out_item_nxt.rgba  = ok4_r ? {alpha_r, tmpr_pkg::EXPAND5[pal_rdata[14:10]],
                                  tmpr_pkg::EXPAND5[pal_rdata[9:5]],
                                  tmpr_pkg::EXPAND5[pal_rdata[4:0]]} : 32'd0;
  end

  logic out_load;
  assign out_load = adv && v4_r && (cmd4_r == tmpr_pkg::CMD_RENDER);

  // valid bits and output handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        v1_r <= in_acc;
        v2_r <= v1_r;
        v3_r <= v2_r;
        v4_r <= v3_r;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv) begin
      cmd1_r  <= in_item.command;
      addr1_r <= in_item.address;
      data1_r <= in_item.data;
      fx1_r   <= in_item.pixel_x[2:0];
      fy1_r   <= in_item.pixel_y[2:0];
      prod1_r <= prod_nxt;
      col1_r  <= col_nxt;

      cmd2_r  <= cmd1_r;
      addr2_r <= addr1_r;
      data2_r <= data1_r[14:0];
      fx2_r   <= fx1_r;
      fy2_r   <= fy1_r;
      ok2_r   <= map_ok;

      cmd3_r  <= cmd2_r;
      addr3_r <= addr2_r;
      data3_r <= data2_r;
      odd3_r  <= ix[0];
      ok3_r   <= char_ok;

      cmd4_r  <= cmd3_r;
      ok4_r   <= pal_ok;
    end
    if (out_load) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // checks
  a_transparent_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.drawn |-> out_item.rgba == 32'd0)
    else $error("transparent pixel carries a color");

  a_drawn_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.drawn |-> out_item.rgba[31:24] == alpha_r)
    else $error("drawn pixel alpha differs from register");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready && v4_r)
    else $error("input stalled without a blocked result");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(v4_r) && $stable(ok4_r) && $stable(cmd4_r))
    else $error("last stage moved during a stall");

endmodule
